### sv/tmte_pkg.sv
// ----------------------------------------------------------------------------
// tmte_pkg
// Shared types and constants for the text-mode terminal engine.
// ----------------------------------------------------------------------------
package tmte_pkg;

    localparam logic [2:0] CMD_PUTC    = 3'd0;
    localparam logic [2:0] CMD_COLOR   = 3'd1;
    localparam logic [2:0] CMD_CURSOR  = 3'd2;
    localparam logic [2:0] CMD_PUTAT   = 3'd3;
    localparam logic [2:0] CMD_READ    = 3'd4;
    localparam logic [2:0] CMD_CLEAR   = 3'd5;
    localparam logic [2:0] CMD_SAVE    = 3'd6;
    localparam logic [2:0] CMD_RESTORE = 3'd7;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] RESET_ATTR = 8'h07;

    typedef enum logic [3:0] {
        ST_INIT,      // clearing pass after reset
        ST_IDLE,
        ST_DECODE,    // cursor updated, decide memory work
        ST_FILL,      // blank sweep, clear or bottom line
        ST_SCR_RD,    // scroll: read cell below
        ST_SCR_WR,    // scroll: write it one line up
        ST_WRITE,     // single cell write
        ST_READ,      // read cell issued
        ST_READ_WAIT,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;   // capture input item
        logic decode;      // run cursor/colour update
        logic ptr_clear;   // pointer to zero
        logic ptr_line;    // pointer to start of bottom line
        logic ptr_inc;
        logic fill_we;     // write blank at pointer
        logic scr_re;      // read pointer+COLUMNS
        logic scr_we;      // write read data at pointer
        logic cell_we;     // write pending cell
        logic cell_re;     // read addressed cell
        logic rd_capture;
        logic init_blank;  // fill uses reset blank
        logic wrap_fix;    // finish a wrapped printable after scroll
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic need_scroll;
        logic need_clear;
        logic need_write;
        logic need_read;
        logic ptr_last;     // pointer at last cell of its sweep
        logic scr_last;     // pointer at last source cell of scroll
    } stat_t;

endpackage

### sv/tmte_ram.sv
// ----------------------------------------------------------------------------
// tmte_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module tmte_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### sv/tmte_ctrl.sv
// ----------------------------------------------------------------------------
// tmte_ctrl
// Command sequencer: sweeps, scroll copy, cell access and result handshake.
// ----------------------------------------------------------------------------
module tmte_ctrl
    import tmte_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t st,
    output ctrl_t ctl
);
    state_t state_reg, state_next;
    logic   wrap_reg, wrap_next;   // scroll came from a wrapped printable

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            wrap_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wrap_reg  <= wrap_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        wrap_next  = wrap_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                ctl.fill_we    = 1'b1;
                ctl.init_blank = 1'b1;
                ctl.ptr_inc    = 1'b1;
                if (st.ptr_last)
                begin
                    ctl.ptr_clear = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                ctl.decode = 1'b1;
                ctl.ptr_clear = 1'b1;
                wrap_next = st.need_write;
                if (st.need_clear)
                    state_next = ST_FILL;
                else if (st.need_scroll)
                    state_next = ST_SCR_RD;
                else if (st.need_write)
                    state_next = ST_WRITE;
                else if (st.need_read)
                    state_next = ST_READ;
                else
                    state_next = ST_OUT;
            end
            ST_SCR_RD:
            begin
                ctl.scr_re = 1'b1;
                state_next = ST_SCR_WR;
            end
            ST_SCR_WR:
            begin
                ctl.scr_we  = 1'b1;
                ctl.ptr_inc = 1'b1;
                if (st.scr_last)
                begin
                    ctl.ptr_line = 1'b1;
                    state_next   = ST_FILL;
                end
                else
                    state_next = ST_SCR_RD;
            end
            ST_FILL:
            begin
                ctl.fill_we = 1'b1;
                ctl.ptr_inc = 1'b1;
                if (st.ptr_last)
                begin
                    if (wrap_reg)
                    begin
                        ctl.wrap_fix = 1'b1;
                        state_next   = ST_WRITE;
                    end
                    else
                        state_next = ST_OUT;
                end
            end
            ST_WRITE:
            begin
                ctl.cell_we = 1'b1;
                state_next  = ST_OUT;
            end
            ST_READ:
            begin
                ctl.cell_re = 1'b1;
                state_next  = ST_READ_WAIT;
            end
            ST_READ_WAIT:
            begin
                ctl.rd_capture = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end
endmodule

### sv/tmte_datapath.sv
// ----------------------------------------------------------------------------
// tmte_datapath
// Cursor, colour and saved registers, cell store and address pointer.
// ----------------------------------------------------------------------------
module tmte_datapath
    import tmte_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_t       ctl,
    output stat_t       st,
    input  logic [2:0]  command,
    input  logic [7:0]  char_code,
    input  logic [7:0]  cell_color,
    input  logic [6:0]  col_x,
    input  logic [4:0]  row_y,
    output logic [6:0]  cursor_col,
    output logic [4:0]  cursor_row,
    output logic [10:0] cursor_linear,
    output logic [7:0]  current_color,
    output logic [7:0]  read_char,
    output logic [7:0]  read_color
);
    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0] LINE_START = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] SCR_LAST   = AW'(CELLS - COLUMNS - 1);
    localparam logic [6:0]    COLS7      = 7'(COLUMNS);
    localparam logic [6:0]    LAST_COL   = 7'(COLUMNS - 1);
    localparam logic [4:0]    LAST_ROW   = 5'(ROWS - 1);

    logic [2:0]  cmd_reg;
    logic [7:0]  ch_reg, colr_reg;
    logic [6:0]  x_reg;
    logic [4:0]  y_reg;
    logic [6:0]  ccol_reg, ccol_next, scol_reg;
    logic [4:0]  crow_reg, crow_next, srow_reg;
    logic [7:0]  attr_reg, attr_next, sattr_reg;
    logic [10:0] lin_reg;
    logic [AW-1:0] ptr_reg, waddr_reg;
    logic [15:0] wdata_reg;
    logic [7:0]  rch_reg, rcol_reg;
    logic        scroll_n, clear_n, write_n, read_n;
    logic [6:0]  wcol_n;
    logic [4:0]  wrow_n;
    logic [15:0] wval_n;
    logic [7:0]  tab_col;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [15:0]   ram_wdata, ram_rdata;

    // put-char and other cursor effects
    always_comb
    begin
        ccol_next = ccol_reg;
        crow_next = crow_reg;
        attr_next = attr_reg;
        scroll_n  = 1'b0;
        clear_n   = 1'b0;
        write_n   = 1'b0;
        read_n    = 1'b0;
        wcol_n    = ccol_reg;
        wrow_n    = crow_reg;
        wval_n    = {attr_reg, ch_reg};
        tab_col   = ({1'b0, ccol_reg} + 8'd8) & 8'hF8;
        case (cmd_reg)
            CMD_PUTC:
            begin
                if (ch_reg == CH_LF)
                begin
                    ccol_next = '0;
                    if (crow_reg == LAST_ROW) scroll_n = 1'b1;
                    else crow_next = crow_reg + 5'd1;
                end
                else if (ch_reg == CH_CR)
                    ccol_next = '0;
                else if (ch_reg == CH_TAB)
                begin
                    if (tab_col >= {1'b0, COLS7})
                    begin
                        ccol_next = '0;
                        if (crow_reg == LAST_ROW) scroll_n = 1'b1;
                        else crow_next = crow_reg + 5'd1;
                    end
                    else
                        ccol_next = tab_col[6:0];
                end
                else if (ch_reg == CH_BS)
                begin
                    if (ccol_reg != '0)
                        ccol_next = ccol_reg - 7'd1;
                    else if (crow_reg != '0)
                    begin
                        crow_next = crow_reg - 5'd1;
                        ccol_next = LAST_COL;
                    end
                    wcol_n  = ccol_next;
                    wrow_n  = crow_next;
                    wval_n  = {attr_reg, CH_SPACE};
                    write_n = (ccol_next < COLS7);
                end
                else
                begin
                    wcol_n = ccol_reg;
                    wrow_n = crow_reg;
                    if (ccol_reg >= COLS7)
                    begin
                        ccol_next = '0;
                        wcol_n    = '0;
                        if (crow_reg == LAST_ROW) scroll_n = 1'b1;
                        else
                        begin
                            crow_next = crow_reg + 5'd1;
                            wrow_n    = crow_next;
                        end
                    end
                    if (ch_reg >= CH_SPACE)
                    begin
                        write_n   = 1'b1;
                        ccol_next = ccol_next + 7'd1;
                    end
                end
            end
            CMD_COLOR:
                attr_next = colr_reg;
            CMD_CURSOR:
            begin
                ccol_next = (x_reg >= COLS7) ? LAST_COL : x_reg;
                crow_next = (y_reg >= 5'(ROWS)) ? LAST_ROW : y_reg;
            end
            CMD_PUTAT:
            begin
                wcol_n  = x_reg;
                wrow_n  = y_reg;
                wval_n  = {colr_reg, ch_reg};
                write_n = (x_reg < COLS7) && (y_reg < 5'(ROWS));
            end
            CMD_READ:
                read_n = 1'b1;
            CMD_CLEAR:
            begin
                clear_n   = 1'b1;
                ccol_next = '0;
                crow_next = '0;
            end
            CMD_SAVE:
                ;
            CMD_RESTORE:
            begin
                ccol_next = scol_reg;
                crow_next = srow_reg;
                attr_next = sattr_reg;
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ccol_reg  <= '0;
            crow_reg  <= '0;
            attr_reg  <= RESET_ATTR;
            scol_reg  <= '0;
            srow_reg  <= '0;
            sattr_reg <= RESET_ATTR;
            ptr_reg   <= '0;
            lin_reg   <= '0;
            rch_reg   <= '0;
            rcol_reg  <= '0;
        end
        else
        begin
            if (ctl.load_item)
            begin
                rch_reg  <= '0;
                rcol_reg <= '0;
            end
            if (ctl.decode)
            begin
                ccol_reg <= ccol_next;
                crow_reg <= crow_next;
                attr_reg <= attr_next;
                lin_reg  <= 11'(crow_next * COLUMNS) + 11'(ccol_next);
                if (cmd_reg == CMD_SAVE)
                begin
                    scol_reg  <= ccol_reg;
                    srow_reg  <= crow_reg;
                    sattr_reg <= attr_reg;
                end
            end
            if (ctl.ptr_clear)
                ptr_reg <= '0;
            else if (ctl.ptr_line)
                ptr_reg <= LINE_START;
            else if (ctl.ptr_inc)
                ptr_reg <= ptr_reg + AW'(1);
            if (ctl.rd_capture && (x_reg < COLS7) && (y_reg < 5'(ROWS)))
            begin
                rch_reg  <= ram_rdata[7:0];
                rcol_reg <= ram_rdata[15:8];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            cmd_reg  <= command;
            ch_reg   <= char_code;
            colr_reg <= cell_color;
            x_reg    <= col_x;
            y_reg    <= row_y;
        end
        if (ctl.decode)
        begin
            waddr_reg <= AW'(wrow_n * COLUMNS) + AW'(wcol_n);
            wdata_reg <= wval_n;
        end
        else if (ctl.wrap_fix)
            waddr_reg <= LINE_START;
    end

    always_comb
    begin
        ram_we    = ctl.fill_we | ctl.scr_we | ctl.cell_we;
        ram_wdata = ctl.init_blank ? {RESET_ATTR, CH_SPACE}
                  : ctl.fill_we    ? {attr_reg, CH_SPACE}
                  : ctl.scr_we     ? ram_rdata
                  : wdata_reg;
        if (ctl.scr_re)
            ram_addr = ptr_reg + AW'(COLUMNS);
        else if (ctl.cell_we)
            ram_addr = waddr_reg;
        else if (ctl.cell_re)
            ram_addr = AW'(y_reg * COLUMNS) + AW'(x_reg);
        else
            ram_addr = ptr_reg;
    end

    tmte_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign st.need_scroll = scroll_n;
    assign st.need_clear  = clear_n;
    assign st.need_write  = write_n;
    assign st.need_read   = read_n;
    assign st.ptr_last    = (ptr_reg == LAST_CELL);
    assign st.scr_last    = (ptr_reg == SCR_LAST);

    assign cursor_col    = ccol_reg;
    assign cursor_row    = crow_reg;
    assign cursor_linear = lin_reg;
    assign current_color = attr_reg;
    assign read_char     = rch_reg;
    assign read_color    = rcol_reg;
endmodule

### sv/text_mode_terminal_engine_unit.sv
// ----------------------------------------------------------------------------
// text_mode_terminal_engine_unit
// Text terminal with a cell store, cursor, colour and saved copy.
// ----------------------------------------------------------------------------
// channel   dir  tdata fields (low bit first)
// s_axis    in   command[2:0] char_code[10:3] cell_color[18:11] col_x[25:19]
//                row_y[30:26]
// m_axis    out  cursor_col[6:0] cursor_row[11:7] cursor_linear[22:12]
//                current_color[30:23] read_char[38:31] read_color[46:39]
//
// result follows decode; a cell write, or a cell read and its capture, comes first
// next item accepted in the cycle after the result is taken
// clear sweeps every cell
// scroll copies each cell one line up through the single RAM port, then blanks the bottom line
// after reset a blanking pass over every cell runs before the first item
// one item at a time; a held result stalls acceptance
// ----------------------------------------------------------------------------
module text_mode_terminal_engine_unit
    import tmte_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // command, char_code, cell_color, col_x, row_y
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // cursor_col, cursor_row, cursor_linear,
                                        // current_color, read_char, read_color
);
    ctrl_t ctl;
    stat_t st;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_linear;
    logic [7:0]  current_color, read_char, read_color;

    tmte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .st        (st),
        .ctl       (ctl)
    );

    tmte_datapath #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .st            (st),
        .command       (s_axis_tdata[2:0]),
        .char_code     (s_axis_tdata[10:3]),
        .cell_color    (s_axis_tdata[18:11]),
        .col_x         (s_axis_tdata[25:19]),
        .row_y         (s_axis_tdata[30:26]),
        .cursor_col    (cursor_col),
        .cursor_row    (cursor_row),
        .cursor_linear (cursor_linear),
        .current_color (current_color),
        .read_char     (read_char),
        .read_color    (read_color)
    );

    assign m_axis_tdata = {1'b0, read_color, read_char, current_color,
                           cursor_linear, cursor_row, cursor_col};

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while result pending");
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_col <= 7'(COLUMNS))
        else $error("cursor column out of range");
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_row < 5'(ROWS))
        else $error("cursor row out of range");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready after accept");
`endif
endmodule
